// ----- hdl/bitmap_id_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator assertion macros
// Concurrent assertion wrappers shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ID_ALLOCATOR_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BIA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap_id_allocator: assertion failed");

// next-cycle implication
`define BIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap_id_allocator: assertion failed");

`endif

// ----- hdl/bia_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator package
// Sizes, types and codes shared by the allocator RTL.
// ----------------------------------------------------------------------------
package bia_pkg;

   localparam int ID_SPACE      = 8192;
   localparam int MAP_WORD_BITS = 64;
   localparam int MAP_DEPTH     = (ID_SPACE + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int ID_FIELD_SPAN = 8192;
   localparam int HI_CAP        = (ID_SPACE < ID_FIELD_SPAN) ? ID_SPACE : ID_FIELD_SPAN;

   localparam int ID_W        = 13;
   localparam int LIMIT_W     = 14;
   localparam int STATUS_W    = 2;
   localparam int BIT_W       = $clog2(MAP_WORD_BITS);
   localparam int ADDR_W      = $clog2(MAP_DEPTH);
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 14;

   typedef logic [ID_W-1:0]          id_type;
   typedef logic [LIMIT_W-1:0]       limit_type;
   typedef logic [MAP_WORD_BITS-1:0] word_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [BIT_W-1:0]         bit_idx_type;
   typedef logic [CSR_INDEX_W-1:0]   csr_index_type;
   typedef logic [CSR_DATA_W-1:0]    csr_data_type;

   localparam id_type    RESET_LOWEST = id_type'(300);
   localparam limit_type RESET_LIMIT  = limit_type'(5000);

   localparam csr_index_type REG_LOWEST_ID = csr_index_type'(0);
   localparam csr_index_type REG_ID_LIMIT  = csr_index_type'(1);

   typedef enum logic {
      OP_ALLOCATE = 1'b0,
      OP_RELEASE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED      = 2'd0,
      ST_NONE_FREE    = 2'd1,
      ST_RELEASED     = 2'd2,
      ST_OUT_OF_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_SCAN = 2'd1,
      FSM_DONE = 2'd2
   } fsm_type;

   typedef struct packed {
      logic        found;
      bit_idx_type index;
   } find_type;

endpackage

// ----- hdl/bia_if.sv -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator channels
// Valid/ready request and response channels of the allocator.
// ----------------------------------------------------------------------------
interface bia_req_if;
   logic            valid;
   logic            ready;
   logic            op;
   bia_pkg::id_type release_id;

   modport source (output valid, op, release_id, input ready);
   modport sink   (input valid, op, release_id, output ready);
endinterface

interface bia_rsp_if;
   logic                           valid;
   logic                           ready;
   bia_pkg::id_type                granted_id;
   logic [bia_pkg::STATUS_W-1:0]   status;

   modport source (output valid, granted_id, status, input ready);
   modport sink   (input valid, granted_id, status, output ready);
endinterface

// ----- hdl/bia_find_zero.sv -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator free-bit finder
// Locates the lowest clear bit of one map word.
// ----------------------------------------------------------------------------
module bia_find_zero (
   input  bia_pkg::word_type word,
   output bia_pkg::find_type result
);

   always_comb begin
      result = '0;
      for (int i = bia_pkg::MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            result.found = 1'b1;
            result.index = bia_pkg::BIT_W'(i);
         end
      end
   end

endmodule

// ----- hdl/bitmap_id_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator
// Lowest-free-first identifier allocator over a word-organized bitmap.
// ----------------------------------------------------------------------------
// The in-use map sits in one 128 x 64 synchronous RAM with a valid bit per
// word, so reset frees every identifier at once and no clearing pass runs.
// An allocate reads one map word per cycle from the word holding lowest_id
// up to the word holding the last usable identifier. A release reads, clears
// and writes back one word; out-of-range releases and allocates on an empty
// range skip the map and answer from the done state. One transaction is in
// work at a time; a finished response waits in an output register while the
// next request is accepted.
// Write lowest_id and id_limit only while idle.
// ----------------------------------------------------------------------------
`include "bitmap_id_allocator_assert.svh"

module bitmap_id_allocator (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  bia_pkg::csr_index_type   csr_index,
   input  bia_pkg::csr_data_type    csr_wdata,
   bia_req_if.sink                  req_if,
   bia_rsp_if.source                rsp_if
);

   bia_pkg::id_type      lowest_id_ff;
   bia_pkg::limit_type   id_limit_ff;

   bia_pkg::fsm_type     state_ff, state_in;
   bia_pkg::op_type      op_ff, op_in;
   bia_pkg::bit_idx_type rel_bit_ff, rel_bit_in;
   bia_pkg::addr_type    scan_addr_ff, scan_addr_in;
   bia_pkg::addr_type    first_addr_ff, first_addr_in;
   bia_pkg::addr_type    last_addr_ff, last_addr_in;
   bia_pkg::addr_type    pend_addr_ff, pend_addr_in;
   bia_pkg::word_type    first_mask_ff, first_mask_in;
   bia_pkg::word_type    last_mask_ff, last_mask_in;
   logic                 issue_ff, issue_in;
   logic                 pend_ff, pend_in;
   bia_pkg::id_type      res_id_ff, res_id_in;
   bia_pkg::status_type  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bia_pkg::id_type      rsp_id_ff, rsp_id_in;
   bia_pkg::status_type  rsp_status_ff, rsp_status_in;

   bia_pkg::word_type    map_mem [bia_pkg::MAP_DEPTH];
   logic [bia_pkg::MAP_DEPTH-1:0] map_vld_ff;
   bia_pkg::word_type    rd_q_ff;
   logic                 rd_qv_ff;

   logic                 mem_rd_en;
   bia_pkg::addr_type    mem_rd_addr;
   logic                 mem_we;
   bia_pkg::addr_type    mem_wr_addr;
   bia_pkg::word_type    mem_wr_data;

   bia_pkg::limit_type   hi;
   bia_pkg::id_type      hi_m1;
   logic                 range_empty;
   logic                 rid_out;
   logic                 req_accept;
   logic                 rsp_free;
   bia_pkg::word_type    eval_word;
   bia_pkg::word_type    masked_word;
   bia_pkg::word_type    hit_bit;
   bia_pkg::find_type    find;

   assign hi = (id_limit_ff > bia_pkg::LIMIT_W'(bia_pkg::HI_CAP)) ?
               bia_pkg::LIMIT_W'(bia_pkg::HI_CAP) : id_limit_ff;
   assign hi_m1       = bia_pkg::ID_W'(hi - bia_pkg::limit_type'(1));
   assign range_empty = bia_pkg::limit_type'(lowest_id_ff) >= hi;
   assign rid_out     = (req_if.release_id < lowest_id_ff) ||
                        (bia_pkg::limit_type'(req_if.release_id) >= hi);

   assign req_if.ready = (state_ff == bia_pkg::FSM_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.granted_id = rsp_id_ff;
   assign rsp_if.status     = rsp_status_ff;

   assign eval_word   = rd_qv_ff ? rd_q_ff : '0;
   assign masked_word = eval_word
                      | ((pend_addr_ff == first_addr_ff) ? first_mask_ff : '0)
                      | ((pend_addr_ff == last_addr_ff)  ? last_mask_ff  : '0);

   bia_find_zero u_find (
      .word   (masked_word),
      .result (find)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      rel_bit_in    = rel_bit_ff;
      scan_addr_in  = scan_addr_ff;
      first_addr_in = first_addr_ff;
      last_addr_in  = last_addr_ff;
      pend_addr_in  = pend_addr_ff;
      first_mask_in = first_mask_ff;
      last_mask_in  = last_mask_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = scan_addr_ff;
      mem_we        = 1'b0;
      mem_wr_addr   = pend_addr_ff;
      mem_wr_data   = eval_word;
      hit_bit       = '0;

      unique case (state_ff)
         bia_pkg::FSM_IDLE: begin
            if (req_accept) begin
               op_in         = bia_pkg::op_type'(req_if.op);
               res_id_in     = '0;
               issue_in      = 1'b0;
               rel_bit_in    = req_if.release_id[bia_pkg::BIT_W-1:0];
               first_mask_in = (bia_pkg::word_type'(1) << lowest_id_ff[bia_pkg::BIT_W-1:0])
                             - bia_pkg::word_type'(1);
               last_mask_in  = ~({bia_pkg::MAP_WORD_BITS{1'b1}} >>
                               (bia_pkg::BIT_W'(bia_pkg::MAP_WORD_BITS - 1)
                                - hi_m1[bia_pkg::BIT_W-1:0]));
               unique case (bia_pkg::op_type'(req_if.op))
                  bia_pkg::OP_ALLOCATE: begin
                     first_addr_in = bia_pkg::ADDR_W'(lowest_id_ff >> bia_pkg::BIT_W);
                     last_addr_in  = bia_pkg::ADDR_W'(hi_m1 >> bia_pkg::BIT_W);
                     scan_addr_in  = bia_pkg::ADDR_W'(lowest_id_ff >> bia_pkg::BIT_W);
                     if (range_empty) begin
                        res_status_in = bia_pkg::ST_NONE_FREE;
                        state_in      = bia_pkg::FSM_DONE;
                     end else begin
                        issue_in = 1'b1;
                        state_in = bia_pkg::FSM_SCAN;
                     end
                  end
                  bia_pkg::OP_RELEASE: begin
                     first_addr_in = bia_pkg::ADDR_W'(req_if.release_id >> bia_pkg::BIT_W);
                     last_addr_in  = bia_pkg::ADDR_W'(req_if.release_id >> bia_pkg::BIT_W);
                     scan_addr_in  = bia_pkg::ADDR_W'(req_if.release_id >> bia_pkg::BIT_W);
                     if (rid_out) begin
                        res_status_in = bia_pkg::ST_OUT_OF_RANGE;
                        state_in      = bia_pkg::FSM_DONE;
                     end else begin
                        issue_in = 1'b1;
                        state_in = bia_pkg::FSM_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         bia_pkg::FSM_SCAN: begin
            if (issue_ff) begin
               mem_rd_en    = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = scan_addr_ff;
               scan_addr_in = scan_addr_ff + bia_pkg::addr_type'(1);
               issue_in     = (scan_addr_ff != last_addr_ff);
            end
            if (pend_ff) begin
               if (op_ff == bia_pkg::OP_RELEASE) begin
                  mem_we        = 1'b1;
                  mem_wr_data   = eval_word & ~(bia_pkg::word_type'(1) << rel_bit_ff);
                  res_status_in = bia_pkg::ST_RELEASED;
                  issue_in      = 1'b0;
                  pend_in       = 1'b0;
                  state_in      = bia_pkg::FSM_DONE;
               end else if (find.found) begin
                  hit_bit       = bia_pkg::word_type'(1) << find.index;
                  mem_we        = 1'b1;
                  mem_wr_data   = eval_word | hit_bit;
                  res_id_in     = bia_pkg::ID_W'({pend_addr_ff, find.index});
                  res_status_in = bia_pkg::ST_GRANTED;
                  issue_in      = 1'b0;
                  pend_in       = 1'b0;
                  state_in      = bia_pkg::FSM_DONE;
               end else if (pend_addr_ff == last_addr_ff) begin
                  res_status_in = bia_pkg::ST_NONE_FREE;
                  issue_in      = 1'b0;
                  pend_in       = 1'b0;
                  state_in      = bia_pkg::FSM_DONE;
               end
            end
         end

         bia_pkg::FSM_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = res_id_ff;
               rsp_status_in = res_status_ff;
               state_in      = bia_pkg::FSM_IDLE;
            end
         end

         default: begin
            state_in = bia_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_id_ff <= bia_pkg::RESET_LOWEST;
         id_limit_ff  <= bia_pkg::RESET_LIMIT;
      end else if (csr_we) begin
         unique case (csr_index)
            bia_pkg::REG_LOWEST_ID: lowest_id_ff <= csr_wdata[bia_pkg::ID_W-1:0];
            bia_pkg::REG_ID_LIMIT:  id_limit_ff  <= csr_wdata[bia_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bia_pkg::FSM_IDLE;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      rel_bit_ff    <= rel_bit_in;
      scan_addr_ff  <= scan_addr_in;
      first_addr_ff <= first_addr_in;
      last_addr_ff  <= last_addr_in;
      pend_addr_ff  <= pend_addr_in;
      first_mask_ff <= first_mask_in;
      last_mask_ff  <= last_mask_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
      end else if (mem_we) begin
         map_vld_ff[mem_wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_q_ff  <= map_mem[mem_rd_addr];
         rd_qv_ff <= map_vld_ff[mem_rd_addr];
      end
      if (mem_we) begin
         map_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   `BIA_ASSERT_IMPL(a_grant_in_range, clock, reset,
      rsp_if.valid && (rsp_if.status == bia_pkg::ST_GRANTED),
      (bia_pkg::limit_type'(rsp_if.granted_id) < hi) && (rsp_if.granted_id >= lowest_id_ff))
   `BIA_ASSERT_IMPL(a_id_zero_unless_granted, clock, reset,
      rsp_if.valid && (rsp_if.status != bia_pkg::ST_GRANTED),
      rsp_if.granted_id == '0)
   `BIA_ASSERT_IMPL(a_scan_within_window, clock, reset,
      (state_ff == bia_pkg::FSM_SCAN) && pend_ff,
      (pend_addr_ff >= first_addr_ff) && (pend_addr_ff <= last_addr_ff))
   `BIA_ASSERT_NEXT(a_write_ends_scan, clock, reset,
      mem_we,
      (state_ff == bia_pkg::FSM_DONE) && !pend_ff)

endmodule

// ----- tb/sv/tb_bitmap_id_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap ID allocator testbench
// Drives allocate and release transactions through the request channel,
// predicts each response from a local copy of the in-use map and the range
// registers, and checks every response in order. A directed table covers the
// range edges and status codes, then random phases sweep several ranges with
// random idling, a long response hold-off and a full drain of the pipeline.
// ----------------------------------------------------------------------------
module tb_bitmap_id_allocator;
   import bia_pkg::*;

   localparam int LONG_HOLD       = 400;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int DRAIN_CYCLES    = 10;
   localparam int RAND_PHASES     = 10;
   localparam int ITEMS_PER_PHASE = 85;
   localparam int DIR_ROWS        = 31;

   typedef enum logic { ROW_TXN, ROW_CFG } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      op_type        op;
      csr_data_type  arg0;
      csr_data_type  arg1;
      logic          typed;
      id_type        exp_id;
      status_type    exp_status;
   } dir_row_type;

   typedef struct {
      id_type     id;
      status_type status;
   } outcome_type;

   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b1, 13'd300,  ST_GRANTED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b1, 13'd301,  ST_GRANTED},
      '{ROW_TXN, OP_RELEASE,  14'd301,  14'd0,     1'b1, 13'd0,    ST_RELEASED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b1, 13'd301,  ST_GRANTED},
      '{ROW_TXN, OP_RELEASE,  14'd299,  14'd0,     1'b1, 13'd0,    ST_OUT_OF_RANGE},
      '{ROW_TXN, OP_RELEASE,  14'd5000, 14'd0,     1'b1, 13'd0,    ST_OUT_OF_RANGE},
      '{ROW_TXN, OP_RELEASE,  14'd4999, 14'd0,     1'b1, 13'd0,    ST_RELEASED},
      '{ROW_TXN, OP_RELEASE,  14'd0,    14'd0,     1'b1, 13'd0,    ST_OUT_OF_RANGE},
      '{ROW_TXN, OP_RELEASE,  14'd8191, 14'd0,     1'b1, 13'd0,    ST_OUT_OF_RANGE},
      '{ROW_CFG, OP_ALLOCATE, 14'd5000, 14'd5000,  1'b0, 13'd0,    ST_GRANTED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b1, 13'd0,    ST_NONE_FREE},
      '{ROW_TXN, OP_RELEASE,  14'd5000, 14'd0,     1'b1, 13'd0,    ST_OUT_OF_RANGE},
      '{ROW_CFG, OP_ALLOCATE, 14'd6000, 14'd10,    1'b0, 13'd0,    ST_GRANTED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b1, 13'd0,    ST_NONE_FREE},
      '{ROW_CFG, OP_ALLOCATE, 14'd0,    14'd8192,  1'b0, 13'd0,    ST_GRANTED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b1, 13'd0,    ST_GRANTED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b0, 13'd0,    ST_GRANTED},
      '{ROW_TXN, OP_RELEASE,  14'd8191, 14'd0,     1'b1, 13'd0,    ST_RELEASED},
      '{ROW_CFG, OP_ALLOCATE, 14'd8191, 14'd16383, 1'b0, 13'd0,    ST_GRANTED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b1, 13'd8191, ST_GRANTED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b1, 13'd0,    ST_NONE_FREE},
      '{ROW_TXN, OP_RELEASE,  14'd8191, 14'd0,     1'b1, 13'd0,    ST_RELEASED},
      '{ROW_TXN, OP_RELEASE,  14'd8190, 14'd0,     1'b1, 13'd0,    ST_OUT_OF_RANGE},
      '{ROW_CFG, OP_ALLOCATE, 14'd0,    14'd0,     1'b0, 13'd0,    ST_GRANTED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b1, 13'd0,    ST_NONE_FREE},
      '{ROW_TXN, OP_RELEASE,  14'd0,    14'd0,     1'b1, 13'd0,    ST_OUT_OF_RANGE},
      '{ROW_CFG, OP_ALLOCATE, 14'd298,  14'd303,   1'b0, 13'd0,    ST_GRANTED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b1, 13'd298,  ST_GRANTED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b1, 13'd299,  ST_GRANTED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b0, 13'd0,    ST_GRANTED},
      '{ROW_TXN, OP_ALLOCATE, 14'd0,    14'd0,     1'b1, 13'd0,    ST_NONE_FREE}
   };

   logic          clock;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   bia_req_if req_ch ();
   bia_rsp_if rsp_ch ();

   bitmap_id_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch)
   );

   bit          id_taken [ID_FIELD_SPAN];
   id_type      lowest_q;
   limit_type   limit_q;
   id_type      held_ids [$];
   outcome_type awaited_outcomes [$];

   int   err_count = 0;
   int   stall_left;
   int   quiet_cycles;
   logic no_idle;
   logic long_hold_req;
   logic long_hold_done;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic int usable_top();
      int hi;
      hi = int'(limit_q);
      if (hi > HI_CAP) hi = HI_CAP;
      return hi;
   endfunction

   function automatic outcome_type resolve_request(input op_type op, input id_type rid);
      outcome_type res;
      int          hi;
      int          i;
      bit          found;
      hi = usable_top();
      found = 1'b0;
      res.id = '0;
      if (op == OP_ALLOCATE) begin
         res.status = ST_NONE_FREE;
         for (i = int'(lowest_q); i < hi && !found; i++) begin
            if (!id_taken[i]) begin
               id_taken[i] = 1'b1;
               res.id = id_type'(i);
               res.status = ST_GRANTED;
               held_ids.push_back(id_type'(i));
               found = 1'b1;
            end
         end
      end else if (rid < lowest_q || int'(rid) >= hi) begin
         res.status = ST_OUT_OF_RANGE;
      end else begin
         id_taken[rid] = 1'b0;
         res.status = ST_RELEASED;
         for (i = 0; i < held_ids.size() && !found; i++) begin
            if (held_ids[i] == rid) begin
               held_ids.delete(i);
               found = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      err_count++;
   endtask

   task automatic send_txn(input op_type op, input id_type rid, input logic typed,
                           input outcome_type typed_res);
      int          gap;
      outcome_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.release_id <= rid;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      res = resolve_request(op, rid);
      if (typed) begin
         awaited_outcomes.push_back(typed_res);
      end else begin
         awaited_outcomes.push_back(res);
      end
   endtask

   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_ranges(input csr_data_type lo, input csr_data_type lim);
      csr_we    <= 1'b1;
      csr_index <= REG_LOWEST_ID;
      csr_wdata <= lo;
      @(posedge clock);
      lowest_q = id_type'(lo);
      csr_index <= REG_ID_LIMIT;
      csr_wdata <= lim;
      @(posedge clock);
      limit_q = limit_type'(lim);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // response side: check, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("unexpected transaction, status", int'(rsp_ch.status), -1);
            end else begin
               if (rsp_ch.granted_id !== awaited_outcomes[0].id)
                  report_mismatch("granted_id", int'(rsp_ch.granted_id),
                                  int'(awaited_outcomes[0].id));
               if (rsp_ch.status !== awaited_outcomes[0].status)
                  report_mismatch("status", int'(rsp_ch.status),
                                  int'(awaited_outcomes[0].status));
               void'(awaited_outcomes.pop_front());
            end
         end
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && !no_idle) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_bitmap_id_allocator failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          row;
      int          phase;
      int          n;
      int          lo;
      int          lim;
      int          span;
      int          r;
      op_type      op;
      id_type      rid;
      outcome_type typed_res;

      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = REG_LOWEST_ID;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.op         = OP_ALLOCATE;
      req_ch.release_id = '0;
      no_idle           = 1'b0;
      long_hold_req     = 1'b0;
      lowest_q          = RESET_LOWEST;
      limit_q           = RESET_LIMIT;
      foreach (id_taken[i]) id_taken[i] = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIR_ROWS; row++) begin
         if (DIR_TABLE[row].kind == ROW_CFG) begin
            wait_quiet();
            write_ranges(DIR_TABLE[row].arg0, DIR_TABLE[row].arg1);
         end else begin
            typed_res.id     = DIR_TABLE[row].exp_id;
            typed_res.status = DIR_TABLE[row].exp_status;
            send_txn(DIR_TABLE[row].op, id_type'(DIR_TABLE[row].arg0),
                     DIR_TABLE[row].typed, typed_res);
         end
      end

      typed_res.id     = '0;
      typed_res.status = ST_GRANTED;
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         case (phase % 5)
            0: begin
               lo  = $urandom_range(0, 8191);
               lim = lo + $urandom_range(1, 40);
            end
            1: begin
               lo  = 0;
               lim = $urandom_range(0, 1) ? 8192 : 16383;
            end
            2: begin
               lo  = $urandom_range(8100, 8191);
               lim = $urandom_range(8192, 16383);
            end
            3: begin
               lo  = $urandom_range(1, 8191);
               lim = $urandom_range(0, lo);
            end
            default: begin
               lo  = $urandom_range(0, 16383);
               lim = $urandom_range(0, 16383);
            end
         endcase
         wait_quiet();
         write_ranges(csr_data_type'(lo), csr_data_type'(lim));
         no_idle <= (phase % 3 == 2);
         if (phase == 1) long_hold_req <= 1'b1;

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // hold the sender until the pipeline is empty
            if (phase == 3 && n == 40) wait_quiet();
            op = ($urandom_range(0, 99) < 55) ? OP_ALLOCATE : OP_RELEASE;
            r  = $urandom_range(0, 99);
            span = usable_top() - int'(lowest_q);
            if (span < 0) span = 2;
            if (r < 50 && held_ids.size() != 0) begin
               rid = held_ids[$urandom_range(0, held_ids.size() - 1)];
            end else if (r < 80) begin
               rid = id_type'(int'(lowest_q) - 1 + $urandom_range(0, span + 2));
            end else begin
               rid = id_type'($urandom_range(0, 8191));
            end
            send_txn(op, rid, 1'b0, typed_res);
         end
      end

      wait_quiet();
      if (err_count == 0) begin
         $display("tb_bitmap_id_allocator passed");
      end else begin
         $display("tb_bitmap_id_allocator failed");
      end
      $finish;
   end

endmodule

// ----- bitmap_id_allocator.f -----
+incdir+hdl
hdl/bia_pkg.sv
hdl/bia_if.sv
hdl/bia_find_zero.sv
hdl/bitmap_id_allocator.sv
tb/sv/tb_bitmap_id_allocator.sv
